// ----- src/brbs_pkg.sv -----
// Shared constants, command codes and types for the byte ring buffer with scan.
package brbs_pkg;

   localparam int DEPTH      = 256;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int STEP_W     = ADDR_W + 1;
   localparam int BYTE_W     = 8;
   localparam int FUNC_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int Q_DEPTH    = 2;
   localparam int QP_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int QC_W       = $clog2(Q_DEPTH + 1);

   localparam logic [BYTE_W-1:0] MASK_RESET = 8'hFF;
   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

   // Register index of index_mask
   localparam logic REG_INDEX_MASK = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH    = 4'd0,
      FN_POP     = 4'd1,
      FN_UNDO    = 4'd2,
      FN_SEEK    = 4'd3,
      FN_SCAN    = 4'd4,
      FN_POP_BRK = 4'd5,
      FN_GET     = 4'd6,
      FN_FLUSH   = 4'd7,
      FN_JUMP    = 4'd8,
      FN_ADVANCE = 4'd9,
      FN_SLICE   = 4'd10,
      FN_SKIP    = 4'd11,
      FN_BAD     = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      op_type            op;
      logic              rd_pos;   // first read at position, else at read pointer
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] position;
   } cmd_type;

   typedef struct packed {
      logic              we;
      logic [BYTE_W-1:0] wdata;
   } cfg_type;

endpackage

// ----- src/brbs_front.sv -----
// Request decode: classifies each request into a command for the queue.
module brbs_front import brbs_pkg::*; (
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [BYTE_W-1:0] req_position,
   output logic              req_stall,
   input  logic              q_full,
   output logic              q_push,
   output cmd_type           q_data
);

   op_type op;

   always_comb begin
      case (req_func)
         FN_PUSH:    op = FN_PUSH;
         FN_POP:     op = FN_POP;
         FN_UNDO:    op = FN_UNDO;
         FN_SEEK:    op = FN_SEEK;
         FN_SCAN:    op = FN_SCAN;
         FN_POP_BRK: op = FN_POP_BRK;
         FN_GET:     op = FN_GET;
         FN_FLUSH:   op = FN_FLUSH;
         FN_JUMP:    op = FN_JUMP;
         FN_ADVANCE: op = FN_ADVANCE;
         FN_SLICE:   op = FN_SLICE;
         FN_SKIP:    op = FN_SKIP;
         default:    op = FN_BAD;
      endcase
   end

   assign q_data.op        = op;
   assign q_data.rd_pos    = (op == FN_GET);
   assign q_data.data_byte = req_data_byte;
   assign q_data.position  = req_position;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// ----- src/brbs_queue.sv -----
// Short command queue between the decode front and the execute back.
module brbs_queue import brbs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_i,
   input  cmd_type push_data,
   output logic    full_o,
   output logic    valid_o,
   input  logic    pop_i,
   output cmd_type pop_data
);

   cmd_type         entry_ff [Q_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] cnt_ff, cnt_in;

   assign full_o   = (cnt_ff == QC_W'(Q_DEPTH));
   assign valid_o  = (cnt_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(Q_DEPTH - 1)) ? '0 : QP_W'(wr_ptr_ff + 1'b1);
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(Q_DEPTH - 1)) ? '0 : QP_W'(rd_ptr_ff + 1'b1);
      end
      if (push_i && !pop_i) begin
         cnt_in = QC_W'(cnt_ff + 1'b1);
      end else if (pop_i && !push_i) begin
         cnt_in = QC_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QC_W'(Q_DEPTH))
      else $error("queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_i |-> (cnt_ff != QC_W'(Q_DEPTH)))
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> (cnt_ff != '0))
      else $error("pop from empty queue");

endmodule

// ----- src/brbs_back.sv -----
// Execute unit: ring storage, pointers, search walk and the result register.
module brbs_back import brbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cmd_type           q_data,
   output logic              q_pop,
   input  cfg_type           cfg,
   output logic [BYTE_W-1:0] mask_o,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic              rsp_status,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic [BYTE_W-1:0] rsp_found_position,
   output logic              rsp_is_full,
   output logic              rsp_is_empty
);

   state_type state_ff, state_in;

   logic [BYTE_W-1:0] mask_ff;
   logic [ADDR_W-1:0] wp_ff, rp_ff;
   logic              full_ff;

   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   logic [STEP_W-1:0] steps_ff, steps_in;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  val_ff;
   logic [BYTE_W-1:0] rdata_ff;
   logic              rvalid_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff;
   logic [BYTE_W-1:0] rsp_rb_ff, rsp_fp_ff;
   logic              rsp_full_ff, rsp_empty_ff;

   logic [ADDR_W-1:0] m;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wp_nx, rp_nx, rp_step, p_nx;
   logic [STEP_W-1:0] steps_nx;
   logic              full_nx, empty_cur, empty_nx;
   logic [BYTE_W-1:0] cellv, rb, fp;
   logic              done, fail, commit, out_free, push_we, match;

   assign m         = mask_ff[ADDR_W-1:0];
   assign cellv     = rvalid_ff ? rdata_ff : '0;
   assign empty_cur = (wp_ff == rp_ff) && !full_ff;
   assign rp_step   = ADDR_W'(rp_ff + 1'b1) & m;
   assign p_nx      = ADDR_W'(p_ff + 1'b1) & m;
   assign steps_nx  = STEP_W'(steps_ff + 1'b1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign match     = (cellv == cmd_ff.data_byte) ||
                      ((cmd_ff.op == FN_SCAN) && ((cellv == CHAR_NL) || (cellv == CHAR_NUL)));
   assign empty_nx  = (wp_nx == rp_nx) && !full_nx;

   // Per-command outcome, evaluated in the execute state
   always_comb begin
      wp_nx   = wp_ff;
      rp_nx   = rp_ff;
      full_nx = full_ff;
      done    = 1'b1;
      fail    = 1'b0;
      rb      = '0;
      fp      = '0;
      push_we = 1'b0;
      case (cmd_ff.op)
         FN_PUSH: begin
            if (full_ff) begin
               fail = 1'b1;
            end else begin
               push_we = 1'b1;
               wp_nx   = ADDR_W'(wp_ff + 1'b1) & m;
               full_nx = ((ADDR_W'(wp_ff + 1'b1) & m) == rp_ff);
            end
         end
         FN_POP: begin
            if (empty_cur) begin
               fail = 1'b1;
            end else begin
               rb      = cellv;
               rp_nx   = rp_step;
               full_nx = 1'b0;
            end
         end
         FN_UNDO: begin
            if (wp_ff != rp_ff) begin
               wp_nx = ADDR_W'(wp_ff - 1'b1) & m;
            end else begin
               fail = 1'b1;
            end
         end
         FN_SEEK, FN_SCAN: begin
            if (empty_cur) begin
               fail = 1'b1;
            end else if (match) begin
               fp = BYTE_W'(p_ff);
            end else if ((p_nx == wp_ff) || (steps_nx == STEP_W'(DEPTH))) begin
               fail = 1'b1;
            end else begin
               done = 1'b0;
            end
         end
         FN_POP_BRK: begin
            if (cellv == cmd_ff.data_byte) begin
               fail = 1'b1;
            end else begin
               rb      = cellv;
               rp_nx   = rp_step;
               full_nx = 1'b0;
            end
         end
         FN_GET: begin
            rb = cellv;
         end
         FN_FLUSH: begin
            rp_nx   = wp_ff;
            full_nx = 1'b0;
         end
         FN_JUMP: begin
            rp_nx = cmd_ff.position[ADDR_W-1:0] & m;
         end
         FN_ADVANCE: begin
            rp_nx = rp_step;
         end
         FN_SLICE: begin
            rb      = cellv;
            rp_nx   = rp_step;
            full_nx = 1'b0;
         end
         FN_SKIP: begin
            rp_nx = ADDR_W'(rp_ff + cmd_ff.position[ADDR_W-1:0]) & m;
         end
         default: begin
            fail = 1'b1;
         end
      endcase
   end

   // Sequencer: fetch from queue and issue first read, then execute / walk
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      p_in         = p_ff;
      steps_in     = steps_ff;
      q_pop        = 1'b0;
      rd_addr      = p_ff;
      commit       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               rd_addr  = q_data.rd_pos ? (q_data.position[ADDR_W-1:0] & m) : rp_ff;
               p_in     = rd_addr;
               steps_in = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!done) begin
               p_in     = p_nx;
               steps_in = steps_nx;
               rd_addr  = p_nx;
            end else if (out_free) begin
               commit       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= MASK_RESET;
         wp_ff        <= '0;
         rp_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         val_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg.we) begin
            mask_ff <= cfg.wdata;
            wp_ff   <= '0;
            rp_ff   <= '0;
            full_ff <= 1'b0;
         end else if (commit) begin
            wp_ff   <= wp_nx;
            rp_ff   <= rp_nx;
            full_ff <= full_nx;
         end
         if (commit && push_we) begin
            val_ff[wp_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      p_ff      <= p_in;
      steps_ff  <= steps_in;
      rdata_ff  <= mem_ff[rd_addr];
      rvalid_ff <= val_ff[rd_addr];
      if (commit && push_we) begin
         mem_ff[wp_ff] <= cmd_ff.data_byte;
      end
      if (commit) begin
         rsp_status_ff <= fail;
         rsp_rb_ff     <= rb;
         rsp_fp_ff     <= fp;
         rsp_full_ff   <= full_nx;
         rsp_empty_ff  <= empty_nx;
      end
   end

   assign mask_o             = mask_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_byte      = rsp_rb_ff;
   assign rsp_found_position = rsp_fp_ff;
   assign rsp_is_full        = rsp_full_ff;
   assign rsp_is_empty       = rsp_empty_ff;

   a_ptr_in_mask: assert property (@(posedge clock) disable iff (reset)
      ((wp_ff & ~m) == '0) && ((rp_ff & ~m) == '0))
      else $error("pointer outside size mask");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (steps_ff < STEP_W'(DEPTH)))
      else $error("search walk ran past depth");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> ((rsp_rb_ff == '0) && (rsp_fp_ff == '0)))
      else $error("failed request carries data");

endmodule

// ----- src/byte_ring_buffer_with_scan.sv -----
// Top level of the byte ring buffer with scan: decode front, queue, execute back, CSR port.
//
// Usage:
//  - req_* channel carries one request (req_func, req_data_byte, req_position); it is
//    taken on a rising edge with req_valid high and req_stall low.
//  - rsp_* channel returns exactly one result per request, in order, held in an
//    output register until taken (rsp_valid high, rsp_stall low).
//  - csr_* is an APB-style port with one register, index_mask at address 0. Writing
//    it clears both pointers and the full flag; write only while the block is idle.
//    csr_pready is tied high; reads at its address return index_mask, others read zero.
//  - Path: a plain request goes from the queue through the fetch step (command and
//    storage read registered) and the execute step into the output register. Seek and
//    scan walk the live region one slot per cycle through the storage read port, over
//    at most DEPTH slots (DEPTH = 256). The back end fetches a new request only after
//    the last one has committed its result.
//  - A two-entry queue decouples decode from execute, so requests keep flowing in
//    while a result waits on rsp_stall; once the queue is full, req_stall rises.
//  - Reset clears pointers, full flag, mask (to 255), queue and the per-slot valid
//    bits; a never-written slot reads as zero, so no clearing pass is needed.
module byte_ring_buffer_with_scan import brbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic [BYTE_W-1:0]     req_position,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output logic [BYTE_W-1:0]     rsp_read_byte,
   output logic [BYTE_W-1:0]     rsp_found_position,
   output logic                  rsp_is_full,
   output logic                  rsp_is_empty,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic              q_push, q_full, q_valid, q_pop;
   cmd_type           q_wdata, q_rdata;
   cfg_type           cfg;
   logic [BYTE_W-1:0] mask;
   logic              reg_hit;

   // Register select ignores the byte-lane bits
   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1] == REG_INDEX_MASK);
   assign csr_pready = 1'b1;
   assign cfg.we     = csr_psel && csr_penable && csr_pwrite && reg_hit;
   assign cfg.wdata  = csr_pwdata[BYTE_W-1:0];
   assign csr_prdata = reg_hit ? CSR_DATA_W'(mask) : '0;

   brbs_front u_front (
      .req_valid     (req_valid),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .req_position  (req_position),
      .req_stall     (req_stall),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_wdata)
   );

   brbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_i    (q_push),
      .push_data (q_wdata),
      .full_o    (q_full),
      .valid_o   (q_valid),
      .pop_i     (q_pop),
      .pop_data  (q_rdata)
   );

   brbs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_data             (q_rdata),
      .q_pop              (q_pop),
      .cfg                (cfg),
      .mask_o             (mask),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_found_position (rsp_found_position),
      .rsp_is_full        (rsp_is_full),
      .rsp_is_empty       (rsp_is_empty)
   );

endmodule
